// File: design/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
// No dependencies; imported by the front, back and top design files.
`default_nettype none

package rdc_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DRAIN,
    BK_RDATA
  } back_state_t;

  // Front to back queue head
  typedef struct packed {
    logic                 valid;
    logic [RADIX_W-1:0]   base;
  } rdc_head_t;

endpackage

`default_nettype wire

// File: design/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: design/rdc_front.sv
// Front end: takes input words, drops zero values, clamps the radix and
// holds up to two pending words for the back end. Depends on rdc_pkg.
`default_nettype none

module rdc_front import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic [RADIX_W-1:0]     radix,
  output rdc_head_t                   head,
  output logic      [VALUE_WIDTH-1:0] head_value,
  input  wire logic                   head_pop
);

  logic [VALUE_WIDTH-1:0] val_q_r  [2];
  logic [RADIX_W-1:0]     base_q_r [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   enq;
  logic                   deq;
  logic [RADIX_W-1:0]     base_clamped;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_clamped = RADIX_MAX;
    end else begin
      base_clamped = radix;
    end
  end

  assign full = (cnt_r == 2'd2);
  // a zero value has no digits: accept and drop it
  assign enq  = push && !full && (in_value != '0);
  assign deq  = head_pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      val_q_r[wr_ptr_r]  <= in_value;
      base_q_r[wr_ptr_r] <= base_clamped;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.base  = base_q_r[rd_ptr_r];
  assign head_value = val_q_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: design/rdc_back.sv
// Back end: bit-serial division by the radix, digit stack in RAM, and
// stack drain into the output register. Depends on rdc_pkg and rdc_ram.
`default_nettype none

module rdc_back import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 31,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rdc_head_t              head,
  input  wire logic [VALUE_WIDTH-1:0] head_value,
  output logic                        head_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [DIGIT_W-1:0]     out_digit,
  output logic                        out_last_digit
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int BIT_W  = $clog2(VALUE_WIDTH);

  back_state_t            state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [BIT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]     out_digit_r, out_digit_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [RADIX_W-1:0]     shifted;
  logic [RADIX_W-1:0]     diff;
  logic                   ge;
  logic [DIGIT_W-1:0]     step_rem;
  logic [VALUE_WIDTH-1:0] step_q;
  logic                   last_bit;
  logic                   stack_room;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic [CNT_W-1:0]       cnt_dec;

  // one restoring-division step: bring down the next dividend bit
  assign shifted    = {rem_r, q_r[VALUE_WIDTH-1]};
  assign diff       = shifted - base_r;
  assign ge         = (shifted >= base_r);
  assign step_rem   = ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
  assign step_q     = {q_r[VALUE_WIDTH-2:0], ge};
  assign last_bit   = (bit_cnt_r == BIT_W'(VALUE_WIDTH - 1));
  assign stack_room = (cnt_r < CNT_W'(STACK_DEPTH));
  assign cnt_dec    = cnt_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (last_bit && (step_q == '0)) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (cnt_r == '0) begin
          state_nxt = BK_IDLE;
        end else if (!out_valid_r) begin
          state_nxt = BK_RDATA;
        end
      end
      BK_RDATA: state_nxt = BK_DRAIN;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !pop;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    head_pop      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_raddr     = cnt_dec[ADDR_W-1:0];
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          head_pop    = 1'b1;
          q_nxt       = head_value;
          base_nxt    = head.base;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          cnt_nxt     = '0;
        end
      end
      BK_DIV: begin
        q_nxt       = step_q;
        rem_nxt     = step_rem;
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (last_bit) begin
          // push the remainder; drop it once the stack is full
          ram_we      = stack_room;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          if (stack_room) cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      BK_DRAIN: begin
        if ((cnt_r != '0) && !out_valid_r) begin
          cnt_nxt = cnt_dec;
        end
      end
      BK_RDATA: begin
        out_valid_nxt = 1'b1;
        out_digit_nxt = ram_rdata;
        out_last_nxt  = (cnt_r == '0);
      end
      default: begin
        head_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (step_rem),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign empty          = !out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("digit stack count past depth");

  a_load_from_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_RDATA))
    else $error("output word loaded outside read-data state");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> ({1'b0, rem_r} < base_r))
    else $error("partial remainder not below radix");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> ((base_r >= RADIX_MIN) && (base_r <= RADIX_MAX)))
    else $error("radix out of range during division");
`endif

endmodule

`default_nettype wire

// File: design/radix_digit_converter_top.sv
// Top level of the radix digit converter: radix register, front queue and
// back-end divider/stack. Depends on rdc_pkg, rdc_front and rdc_back.
`default_nettype none

// Each nonzero value is divided repeatedly by the radix (register clamped to
// 2..16) and its digits come out most significant first, the final digit
// flagged by out_last_digit; a zero value is accepted and yields nothing.
// The divider is bit-serial, one quotient bit per cycle; each finished
// division pushes one digit onto the stack, and the stack then drains
// through the one-entry output register, waiting while a digit is held.
// The front end holds two pending values, so input is taken while the back
// end works. Write cfg_wr_data only while the block is idle.
module radix_digit_converter_top import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 31,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [RADIX_W-1:0]     cfg_wr_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [DIGIT_W-1:0]     out_digit,
  output logic                        out_last_digit
);

  logic [RADIX_W-1:0]     radix_r;
  rdc_head_t              head;
  logic [VALUE_WIDTH-1:0] head_value;
  logic                   head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  rdc_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_value  (in_value),
    .radix     (radix_r),
    .head      (head),
    .head_value(head_value),
    .head_pop  (head_pop)
  );

  rdc_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_value    (head_value),
    .head_pop      (head_pop),
    .empty         (empty),
    .pop           (pop),
    .out_digit     (out_digit),
    .out_last_digit(out_last_digit)
  );

endmodule

`default_nettype wire
